FILE: hdl/text_line_view_filter_unit_macros.svh
// Assertion macros used by the line view filter back end.
// Define ASSERT_OFF to compile the checks away.
`ifndef TEXT_LINE_VIEW_FILTER_UNIT_MACROS_SVH
`define TEXT_LINE_VIEW_FILTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define TLVF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TLVF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TLVF_ASSERT(lbl, prop, msg)
`define TLVF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hdl/tlvf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlvf_pkg
// Types and constants shared by the line view filter front, queue and back.
// ---------------------------------------------------------------------------
package tlvf_pkg;

  localparam int CountDigitsDefault = 10;
  localparam int CountDigitsMax     = 10;
  localparam int LenW               = $clog2(CountDigitsMax + 5);
  localparam int DigIdxW            = $clog2(CountDigitsMax);
  localparam int QueueDepth         = 2;
  localparam int MinNumWidth        = 6;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChNl      = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCaret   = 8'h5E;
  localparam logic [7:0] ChUpperI  = 8'h49;
  localparam logic [7:0] ChQuest   = 8'h3F;
  localparam logic [7:0] ChDel     = 8'h7F;
  localparam logic [7:0] CtrlLimit = 8'd32;
  localparam logic [7:0] CaretOfs  = 8'd64;
  localparam logic [3:0] DigitHigh = 4'h3;

  typedef enum logic [2:0] {
    REG_NUMBER_ALL      = 3'd0,
    REG_NUMBER_NONBLANK = 3'd1,
    REG_SQUEEZE_BLANK   = 3'd2,
    REG_SHOW_ENDS       = 3'd3,
    REG_SHOW_TABS       = 3'd4,
    REG_SHOW_ALL        = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic number_all_lines;
    logic number_nonblank_lines;
    logic squeeze_blank_runs;
    logic show_line_ends;
    logic show_tabs;
    logic show_all_visible;
  } cfg_t;

  // one formatting job: optional number prefix followed by one or two body bytes
  typedef struct packed {
    logic [CountDigitsMax-1:0][3:0] digits;
    logic [LenW-1:0]                num_len;
    logic [LenW-1:0]                num_width;
    logic [LenW-1:0]                prefix_len;
    logic [LenW-1:0]                total;
    logic [7:0]                     body0;
    logic [7:0]                     body1;
  } job_t;

endpackage
`default_nettype wire

FILE: hdl/tlvf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlvf_front
// Accepts input items, tracks line state and the BCD line counter, holds the
// option registers and turns each unsqueezed item into a formatting job.
// ---------------------------------------------------------------------------
module tlvf_front import tlvf_pkg::*; #(
  parameter int COUNT_DIGITS = CountDigitsDefault
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_sof,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic       cfg_data,
  output logic            push,
  output job_t            push_job,
  input  wire logic       q_ready
);

  cfg_t       cfg_r;
  logic       als_r, als_nxt;
  logic [1:0] brc_r, brc_nxt;
  logic [3:0] cnt_r   [COUNT_DIGITS];
  logic [3:0] cnt_nxt [COUNT_DIGITS];

  logic                    cur_als;
  logic [1:0]              cur_brc, sq_brc;
  logic [3:0]              cur_dig [COUNT_DIGITS];
  logic [3:0]              inc_dig [COUNT_DIGITS];
  logic [COUNT_DIGITS-1:0] carry;
  logic [LenW-1:0]         num_len, num_width, body_len;
  logic                    is_nl, drop, has_num, accept;
  logic [7:0]              b0, b1;

  assign cfg_ready = 1'b1;
  assign in_tready = q_ready;
  assign accept    = in_tvalid & in_tready;
  assign is_nl     = (in_byte == ChNl);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUMBER_ALL:      cfg_r.number_all_lines      <= cfg_data;
        REG_NUMBER_NONBLANK: cfg_r.number_nonblank_lines <= cfg_data;
        REG_SQUEEZE_BLANK:   cfg_r.squeeze_blank_runs    <= cfg_data;
        REG_SHOW_ENDS:       cfg_r.show_line_ends        <= cfg_data;
        REG_SHOW_TABS:       cfg_r.show_tabs             <= cfg_data;
        REG_SHOW_ALL:        cfg_r.show_all_visible      <= cfg_data;
        default:             cfg_r                       <= cfg_r;
      endcase
    end
  end

  // start of file clears the line state ahead of this item
  always_comb begin
    cur_als = in_sof | als_r;
    cur_brc = in_sof ? 2'd0 : brc_r;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      cur_dig[i] = in_sof ? 4'd0 : cnt_r[i];
    end
    carry[0] = 1'b1;
    for (int i = 1; i < COUNT_DIGITS; i++) begin
      carry[i] = carry[i-1] & (cur_dig[i-1] >= 4'd9);
    end
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (carry[i]) begin
        inc_dig[i] = (cur_dig[i] >= 4'd9) ? 4'd0 : cur_dig[i] + 4'd1;
      end else begin
        inc_dig[i] = cur_dig[i];
      end
    end
    num_len = LenW'(1);
    for (int i = 1; i < COUNT_DIGITS; i++) begin
      if (inc_dig[i] != 4'd0) num_len = LenW'(i + 1);
    end
    num_width = (num_len < LenW'(MinNumWidth)) ? LenW'(MinNumWidth) : num_len;
  end

  always_comb begin
    sq_brc  = (cur_brc == 2'd2) ? 2'd2 : cur_brc + 2'd1;
    drop    = 1'b0;
    has_num = 1'b0;
    als_nxt = cur_als;
    brc_nxt = cur_brc;
    if (cur_als) begin
      if (is_nl) begin
        if (cfg_r.squeeze_blank_runs) begin
          brc_nxt = sq_brc;
          drop    = (sq_brc == 2'd2);
        end
        has_num = cfg_r.number_all_lines & ~drop;
      end else begin
        has_num = cfg_r.number_all_lines | cfg_r.number_nonblank_lines;
        als_nxt = 1'b0;
        brc_nxt = 2'd0;
      end
    end else if (is_nl) begin
      als_nxt = 1'b1;
      brc_nxt = 2'd0;
    end
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      cnt_nxt[i] = has_num ? inc_dig[i] : cur_dig[i];
    end
  end

  // body bytes
  always_comb begin
    b0       = in_byte;
    b1       = ChNl;
    body_len = LenW'(1);
    if (is_nl) begin
      if (cfg_r.show_line_ends | cfg_r.show_all_visible) begin
        b0       = ChDollar;
        body_len = LenW'(2);
      end
    end else if (in_byte == ChTab) begin
      if (cfg_r.show_tabs | cfg_r.show_all_visible) begin
        b0       = ChCaret;
        b1       = ChUpperI;
        body_len = LenW'(2);
      end
    end else if (cfg_r.show_all_visible && in_byte < CtrlLimit) begin
      b0       = ChCaret;
      b1       = in_byte + CaretOfs;
      body_len = LenW'(2);
    end else if (cfg_r.show_all_visible && in_byte == ChDel) begin
      b0       = ChCaret;
      b1       = ChQuest;
      body_len = LenW'(2);
    end
  end

  always_comb begin
    push_job = '0;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      push_job.digits[i] = inc_dig[i];
    end
    push_job.num_len    = num_len;
    push_job.num_width  = num_width;
    push_job.prefix_len = has_num ? num_width + LenW'(2) : '0;
    push_job.total      = push_job.prefix_len + body_len;
    push_job.body0      = b0;
    push_job.body1      = b1;
  end

  assign push = accept & ~drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      als_r <= 1'b1;
      brc_r <= 2'd0;
      for (int i = 0; i < COUNT_DIGITS; i++) cnt_r[i] <= 4'd0;
    end else if (accept) begin
      als_r <= als_nxt;
      brc_r <= brc_nxt;
      for (int i = 0; i < COUNT_DIGITS; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/tlvf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tlvf_queue
// Short job queue between the classifying front and the emitting back.
// ---------------------------------------------------------------------------
module tlvf_queue import tlvf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  output logic      q_ready,
  output logic      q_valid,
  output job_t      q_head,
  input  wire logic pop
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            slot_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  assign q_ready = (cnt_r != CntW'(QueueDepth));
  assign q_valid = (cnt_r != '0);
  assign q_head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PtrW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PtrW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CntW'(1);
        2'b01:   cnt_r <= cnt_r - CntW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/tlvf_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "text_line_view_filter_unit_macros.svh"
// ---------------------------------------------------------------------------
// tlvf_back
// Takes jobs off the queue and streams their bytes: pad spaces, line number
// digits, two spaces, then the body bytes; tlast marks the final byte.
// ---------------------------------------------------------------------------
module tlvf_back import tlvf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  job_t       q_head,
  output logic       pop,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic            busy_r;
  job_t            job_r;
  logic [LenW-1:0] pos_r;
  logic [LenW-1:0] pad_end, body_pos;
  logic [DigIdxW-1:0] dig_idx;
  logic            take;

  assign out_tvalid = busy_r;
  assign out_last   = (pos_r == job_r.total - LenW'(1));
  assign take       = out_tvalid & out_tready;
  assign pop        = q_valid & (~busy_r | (take & out_last));

  assign pad_end  = job_r.num_width - job_r.num_len;
  assign body_pos = pos_r - job_r.prefix_len;
  assign dig_idx  = DigIdxW'(job_r.num_width - LenW'(1) - pos_r);

  always_comb begin
    if (pos_r < job_r.prefix_len) begin
      if (pos_r >= pad_end && pos_r < job_r.num_width) begin
        out_byte = {DigitHigh, job_r.digits[dig_idx]};
      end else begin
        out_byte = ChSpace;
      end
    end else if (body_pos == '0) begin
      out_byte = job_r.body0;
    end else begin
      out_byte = job_r.body1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      pos_r  <= '0;
    end else if (take && out_last) begin
      busy_r <= 1'b0;
    end else if (take) begin
      pos_r <= pos_r + LenW'(1);
    end
  end

  `TLVF_ASSERT(a_pos_in_job, busy_r |-> (pos_r < job_r.total), "byte position past job end")
  `TLVF_ASSERT(a_job_nonempty, busy_r |-> (job_r.total != '0), "empty job loaded")
  `TLVF_ASSERT(a_run_continues, (take && !out_last) |=> out_tvalid, "item run broken")

endmodule
`default_nettype wire

FILE: hdl/text_line_view_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// text_line_view_filter_unit
// Line view filter: line numbering, blank-run squeezing and visible control
// characters on a byte stream.
// ---------------------------------------------------------------------------
// Each input item gives zero to fourteen output items, the last flagged by
// out_tlast. The back end sends one byte per cycle while out_tready is high,
// so one-byte items flow at one item per cycle; longer items hold the output
// until all their bytes are out. The front end classifies an item in the
// cycle it is accepted and hands a job to a two-entry queue, so input keeps
// flowing while a numbered line prefix drains; in_tready drops only when the
// queue is full. Squeezed empty lines are accepted and produce nothing. The
// user must write options through the cfg port only while the stream is
// idle; the block does not enforce this. cfg_ready is always high.
module text_line_view_filter_unit import tlvf_pkg::*; #(
  parameter int COUNT_DIGITS = CountDigitsDefault
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] byte_in
  input  wire logic [0:0] in_tuser,   // [0] start_of_file
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] byte_out
  output logic            out_tlast,  // last_of_run
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic       cfg_data
);

  logic push, pop, q_ready, q_valid;
  job_t push_job, q_head;

  tlvf_front #(
    .COUNT_DIGITS(COUNT_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_sof    (in_tuser[0]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_job  (push_job),
    .q_ready   (q_ready)
  );

  tlvf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop)
  );

  tlvf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule
`default_nettype wire

FILE: sim/text_line_view_filter_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_line_view_filter_unit_test
// Self-checking bench for the line view filter. A directed table covers byte
// extremes, caret forms, numbering and blank-run squeezing; random text under
// changing options follows. Every output item is checked against typed bytes
// or a numbering and formatting predictor. Both sides idle in random bursts.
// ---------------------------------------------------------------------------
module text_line_view_filter_unit_test;
  import tlvf_pkg::*;

  localparam int NumDigits    = CountDigitsDefault;
  localparam int SettleCycles = 30;
  localparam int LongHold     = 300;
  localparam int DirRows      = 25;
  localparam int RandPhases   = 8;
  localparam int PhaseItems   = 17;

  // indexes past the last register; writes there must be ignored
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  // '{number_all, number_nonblank, squeeze, show_ends, show_tabs, show_all}
  localparam cfg_t CfgPlain       = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam cfg_t CfgVisible     = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam cfg_t CfgTabs        = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
  localparam cfg_t CfgEnds        = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam cfg_t CfgNumSqueeze  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam cfg_t CfgNumNonblank = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam cfg_t CfgNumBoth     = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam cfg_t CfgEverything  = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_byte_t;

  // n_typed = 0: expectation comes from the predictor
  typedef struct packed {
    cfg_t       opts;
    logic [7:0] ch;
    logic       sof;
    logic [1:0] n_typed;
    logic [7:0] t0;
    logic [7:0] t1;
  } dir_row_t;

  localparam dir_row_t DirTab [DirRows] = '{
    '{CfgPlain,       8'h41, 1'b1, 2'd1, 8'h41,   8'h00},
    '{CfgPlain,       8'h00, 1'b0, 2'd1, 8'h00,   8'h00},
    '{CfgPlain,       8'hFF, 1'b0, 2'd1, 8'hFF,   8'h00},
    '{CfgPlain,       ChTab, 1'b0, 2'd1, ChTab,   8'h00},
    '{CfgPlain,       ChNl,  1'b0, 2'd1, ChNl,    8'h00},
    '{CfgVisible,     8'h00, 1'b0, 2'd2, ChCaret, 8'h40},
    '{CfgVisible,     8'h1F, 1'b0, 2'd2, ChCaret, 8'h5F},
    '{CfgVisible,     ChDel, 1'b0, 2'd2, ChCaret, ChQuest},
    '{CfgVisible,     8'hFF, 1'b0, 2'd1, 8'hFF,   8'h00},
    '{CfgVisible,     ChTab, 1'b0, 2'd2, ChCaret, ChUpperI},
    '{CfgVisible,     ChNl,  1'b0, 2'd2, ChDollar, ChNl},
    '{CfgTabs,        ChTab, 1'b0, 2'd2, ChCaret, ChUpperI},
    '{CfgEnds,        ChNl,  1'b0, 2'd2, ChDollar, ChNl},
    '{CfgNumSqueeze,  8'h78, 1'b1, 2'd0, 8'h00,   8'h00},
    '{CfgNumSqueeze,  ChNl,  1'b0, 2'd0, 8'h00,   8'h00},
    '{CfgNumSqueeze,  ChNl,  1'b0, 2'd0, 8'h00,   8'h00},
    '{CfgNumSqueeze,  ChNl,  1'b0, 2'd0, 8'h00,   8'h00},
    '{CfgNumSqueeze,  ChNl,  1'b0, 2'd0, 8'h00,   8'h00},
    '{CfgNumSqueeze,  8'h79, 1'b0, 2'd0, 8'h00,   8'h00},
    '{CfgNumNonblank, ChNl,  1'b0, 2'd0, 8'h00,   8'h00},
    '{CfgNumNonblank, ChNl,  1'b0, 2'd0, 8'h00,   8'h00},
    '{CfgNumNonblank, 8'h7A, 1'b0, 2'd0, 8'h00,   8'h00},
    '{CfgNumBoth,     ChNl,  1'b0, 2'd0, 8'h00,   8'h00},
    '{CfgNumBoth,     ChNl,  1'b0, 2'd0, 8'h00,   8'h00},
    '{CfgNumBoth,     8'h71, 1'b1, 2'd0, 8'h00,   8'h00}
  };

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic [0:0] in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic       cfg_data;

  text_line_view_filter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor state
  cfg_t       opts;
  logic       at_start;
  logic [1:0] blank_cnt;
  logic [3:0] line_digits [NumDigits];
  out_byte_t  run_q [$];
  out_byte_t  expected_bytes [$];

  int  mismatches;
  int  bytes_checked;
  int  items_sent;
  int  settings_used;
  bit  tx_idle_on;
  bit  rx_idle_on;
  bit  long_hold_req;
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for the filter to drain");
    $display("text_line_view_filter_unit test failed");
    $finish;
  end

  function automatic void clear_lines();
    at_start  = 1'b1;
    blank_cnt = 2'd0;
    for (int i = 0; i < NumDigits; i++) line_digits[i] = 4'd0;
  endfunction

  function automatic void put(logic [7:0] b);
    run_q.push_back('{b, 1'b0});
  endfunction

  function automatic void mark_last();
    out_byte_t r;
    r = run_q.pop_back();
    r.last = 1'b1;
    run_q.push_back(r);
  endfunction

  // BCD count is bumped before printing; pad to six places, then two spaces
  function automatic void put_line_number();
    int len;
    len = 1;
    for (int i = 0; i < NumDigits; i++) begin
      if (line_digits[i] >= 4'd9) begin
        line_digits[i] = 4'd0;
      end else begin
        line_digits[i] = line_digits[i] + 4'd1;
        break;
      end
    end
    for (int i = NumDigits - 1; i > 0; i--) begin
      if (line_digits[i] != 4'd0) begin
        len = i + 1;
        break;
      end
    end
    for (int i = len; i < MinNumWidth; i++) put(ChSpace);
    for (int i = len - 1; i >= 0; i--) put({DigitHigh, line_digits[i]});
    put(ChSpace);
    put(ChSpace);
  endfunction

  function automatic void put_line_end();
    if (opts.show_line_ends || opts.show_all_visible) put(ChDollar);
    put(ChNl);
  endfunction

  // fills run_q with the bytes one input item gives
  function automatic void format_item(logic [7:0] c, logic sof);
    run_q.delete();
    if (sof) clear_lines();
    if (at_start) begin
      if (c == ChNl) begin
        if (opts.squeeze_blank_runs) begin
          if (blank_cnt < 2'd2) blank_cnt = blank_cnt + 2'd1;
          if (blank_cnt > 2'd1) return;
        end
        if (opts.number_all_lines) put_line_number();
        put_line_end();
        mark_last();
        return;
      end
      if (opts.number_all_lines || opts.number_nonblank_lines) put_line_number();
      at_start  = 1'b0;
      blank_cnt = 2'd0;
    end
    if (c == ChNl) begin
      blank_cnt = 2'd0;
      put_line_end();
      at_start = 1'b1;
    end else if (c == ChTab) begin
      if (opts.show_tabs || opts.show_all_visible) begin
        put(ChCaret);
        put(ChUpperI);
      end else begin
        put(ChTab);
      end
    end else if (opts.show_all_visible && c < CtrlLimit) begin
      put(ChCaret);
      put(c + CaretOfs);
    end else if (opts.show_all_visible && c == ChDel) begin
      put(ChCaret);
      put(ChQuest);
    end else begin
      put(c);
    end
    mark_last();
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  // leaves in_tvalid high; the caller lowers it for a gap
  task automatic push_item(input logic [7:0] b, input logic sof, input logic [1:0] n_typed,
                           input logic [7:0] t0, input logic [7:0] t1);
    in_tvalid   <= 1'b1;
    in_tdata    <= b;
    in_tuser[0] <= sof;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    format_item(b, sof);
    if (n_typed == 2'd0) begin
      foreach (run_q[i]) expected_bytes.push_back(run_q[i]);
    end else if (n_typed == 2'd1) begin
      expected_bytes.push_back('{t0, 1'b1});
    end else begin
      expected_bytes.push_back('{t0, 1'b0});
      expected_bytes.push_back('{t1, 1'b1});
    end
  endtask

  task automatic offer_item(input logic [7:0] b, input logic sof);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    push_item(b, sof, 2'd0, 8'h00, 8'h00);
  endtask

  // squeezed lines give nothing, so allow the pipeline to empty too
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NUMBER_ALL:      opts.number_all_lines      = v;
      REG_NUMBER_NONBLANK: opts.number_nonblank_lines = v;
      REG_SQUEEZE_BLANK:   opts.squeeze_blank_runs    = v;
      REG_SHOW_ENDS:       opts.show_line_ends        = v;
      REG_SHOW_TABS:       opts.show_tabs             = v;
      REG_SHOW_ALL:        opts.show_all_visible      = v;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input cfg_t c, input bit spare);
    write_reg(REG_NUMBER_ALL, c.number_all_lines);
    write_reg(REG_NUMBER_NONBLANK, c.number_nonblank_lines);
    write_reg(REG_SQUEEZE_BLANK, c.squeeze_blank_runs);
    write_reg(REG_SHOW_ENDS, c.show_line_ends);
    write_reg(REG_SHOW_TABS, c.show_tabs);
    write_reg(REG_SHOW_ALL, c.show_all_visible);
    if (spare) begin
      write_reg(RegSpareLo, ~c.number_all_lines);
      write_reg(RegSpareHi, 1'($urandom_range(0, 1)));
    end
    cfg_valid <= 1'b0;
    settings_used++;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)      return ChNl;
    else if (r < 20) return ChTab;
    else if (r < 28) return 8'($urandom_range(0, 31));
    else if (r < 32) return ChDel;
    else if (r < 42) return 8'($urandom_range(128, 255));
    else if (r < 52) return 8'($urandom_range(0, 255));
    else             return 8'($urandom_range(32, 126));
  endfunction

  // random text with occasional runs of empty lines and restarts of file
  task automatic send_text(input int n);
    int nl_left;
    logic [7:0] b;
    nl_left = 0;
    for (int i = 0; i < n; i++) begin
      if (nl_left > 0) begin
        b = ChNl;
        nl_left--;
      end else begin
        if ($urandom_range(0, 15) == 0) nl_left = $urandom_range(1, 4);
        b = pick_byte();
      end
      offer_item(b, ($urandom_range(0, 39) == 0));
    end
  endtask

  // result side: check each accepted item, then pick next tready
  initial begin
    out_tready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        bytes_checked++;
        if (expected_bytes.size() == 0) begin
          note_failure($sformatf("unexpected byte %h last %b", out_tdata, out_tlast));
        end else begin
          out_byte_t e;
          e = expected_bytes.pop_front();
          if (out_tdata !== e.data || out_tlast !== e.last)
            note_failure($sformatf("byte %h last %b, expected byte %h last %b",
                                   out_tdata, out_tlast, e.data, e.last));
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LongHold;
      end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= rst_n;
      end
    end
  end

  initial begin
    cfg_t rnd_cfg;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tuser    <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_NUMBER_ALL;
    cfg_data    <= 1'b0;
    rst_n       <= 1'b0;
    mismatches    = 0;
    bytes_checked = 0;
    items_sent    = 0;
    settings_used = 0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    long_hold_req = 1'b0;
    opts = CfgPlain;
    clear_lines();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_cfg(CfgPlain, 1'b1);
    for (int i = 0; i < DirRows; i++) begin
      if (DirTab[i].opts != opts) begin
        settle_block();
        apply_cfg(DirTab[i].opts, 1'b0);
      end
      push_item(DirTab[i].ch, DirTab[i].sof, DirTab[i].n_typed, DirTab[i].t0, DirTab[i].t1);
    end

    for (int p = 0; p < RandPhases; p++) begin
      settle_block();
      if (p == 0) begin
        rnd_cfg = CfgEverything;
      end else if (p == 1) begin
        rnd_cfg = CfgPlain;
      end else begin
        rnd_cfg = cfg_t'(6'($urandom_range(0, 63)));
      end
      apply_cfg(rnd_cfg, ($urandom_range(0, 1) == 1));
      tx_idle_on = (p != 4) && (p != RandPhases - 1);
      rx_idle_on = tx_idle_on;
      // output stalled for a long stretch while input keeps coming
      if (p == 3) long_hold_req = 1'b1;
      send_text(PhaseItems);
    end

    settle_block();
    if (expected_bytes.size() != 0)
      note_failure($sformatf("%0d expected bytes never came", expected_bytes.size()));
    $display("Sent %0d items under %0d option settings; %0d output bytes checked",
             items_sent, settings_used, bytes_checked);
    if (mismatches == 0) begin
      $display("text_line_view_filter_unit test passed");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("text_line_view_filter_unit test failed");
    end
    $finish;
  end

endmodule
